/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the smoother RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every rising clock edge outside reset.
`define AVS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// When the trigger holds, the consequence holds in the next cycle.
`define AVS_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* src/avs_pkg.sv */
// ----------------------------------------------------------------------------
// avs_pkg
// Types, constants and helpers for the adaptive velocity smoother.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package avs_pkg;

  localparam int SampleBitsDef    = 24;
  localparam int ExpTableDepthDef = 256;

  // Beyond this index every table entry rounds to zero.
  localparam int ExpRomCap = 384;
  localparam logic [63:0] ExpStepR = 64'd4162825044;
  localparam int ArgFracBits = 11;

  localparam int AluW    = 64;
  localparam int AluCntW = 7;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 18;

  localparam logic [17:0] FsRst     = 18'd48000;
  localparam logic [13:0] FastRst   = 14'd500;
  localparam logic [15:0] SlowRst   = 16'd8000;
  localparam logic [11:0] SensRst   = 12'd512;
  localparam logic [11:0] HystRst   = 12'd205;
  localparam logic [15:0] FixedRst  = 16'd10000;

  localparam logic [17:0] FsMin = 18'd8000,  FsMax = 18'd192000;
  localparam logic [17:0] FastMin = 18'd100, FastMax = 18'd10000;
  localparam logic [17:0] SlowMin = 18'd1000, SlowMax = 18'd50000;
  localparam logic [17:0] SensMin = 18'd26,  SensMax = 18'd2560;
  localparam logic [17:0] HystMin = 18'd41,  HystMax = 18'd2048;
  localparam logic [17:0] FixedMin = 18'd100, FixedMax = 18'd50000;

  localparam logic [63:0] EtaNum  = 64'd65536000000;
  localparam logic [28:0] OneQ27  = 29'd134217728;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FS    = 3'd0,
    REG_FAST  = 3'd1,
    REG_SLOW  = 3'd2,
    REG_SENS  = 3'd3,
    REG_HYST  = 3'd4,
    REG_ADAPT = 3'd5,
    REG_FIXED = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic {
    EXP_FOR_TAU,
    EXP_FOR_ETA
  } exp_use_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_THR,
    ST_VF,
    ST_MODE,
    ST_ARG,
    ST_EXP_HI,
    ST_EXP_LO,
    ST_EXP_MUL,
    ST_TAU,
    ST_DEN,
    ST_ETA_DIV,
    ST_COEF_DIV,
    ST_ACC_MUL,
    ST_OUT
  } avs_state_e;

  typedef struct packed {
    logic               start;
    alu_op_e            op;
    logic [AluW-1:0]    a;
    logic [AluW-1:0]    b;
    logic [AluCntW-1:0] n;
  } alu_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [AluW-1:0] result;
  } alu_rsp_t;

  function automatic logic [17:0] clamp18(input logic [17:0] v,
                                          input logic [17:0] lo,
                                          input logic [17:0] hi);
    logic [17:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/avs_in_if.sv */
// ----------------------------------------------------------------------------
// avs_in_if
// Input sample channel: valid, ready and one signed sample word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface avs_in_if #(
  parameter int W = 24
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

/* src/avs_out_if.sv */
// ----------------------------------------------------------------------------
// avs_out_if
// Result channel: smoothed sample, mode flag and time constant used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface avs_out_if #(
  parameter int W = 24
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;
  logic                fast_mode;
  logic [15:0]         tau_used_us;

  modport source (output valid, output sample_out, output fast_mode,
                  output tau_used_us, input ready);
  modport sink   (input valid, input sample_out, input fast_mode,
                  input tau_used_us, output ready);
endinterface

`default_nettype wire

/* src/avs_cfg_if.sv */
// ----------------------------------------------------------------------------
// avs_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface avs_cfg_if import avs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/avs_alu.sv */
// ----------------------------------------------------------------------------
// avs_alu
// Shared 64-bit shift-add multiplier and restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module avs_alu import avs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);

  logic               busy_q;
  logic               done_q;
  alu_op_e            op_q;
  logic [AluCntW-1:0] cnt_q;
  logic [AluW-1:0]    acc_q, acc_d;
  logic [AluW-1:0]    x_q, x_d;
  logic [AluW-1:0]    y_q, y_d;
  logic [AluW-1:0]    quo_q, quo_d;

  logic [AluW-1:0]    rsh;
  logic [AluW-1:0]    add_x, add_y;
  logic               add_sub;
  logic [AluW:0]      sum;
  logic [AluCntW-1:0] pre_sh;

  assign pre_sh = AluCntW'(AluW) - req_i.n;

  always_comb begin
    rsh     = {acc_q[AluW-2:0], x_q[AluW-1]};
    add_sub = (op_q == ALU_DIV);
    add_x   = add_sub ? rsh : acc_q;
    add_y   = add_sub ? ~y_q : x_q;
    sum     = {1'b0, add_x} + {1'b0, add_y} + {{AluW{1'b0}}, add_sub};
    acc_d   = acc_q;
    x_d     = x_q << 1;
    y_d     = y_q;
    quo_d   = quo_q;
    unique case (op_q)
      ALU_MUL: begin
        if (y_q[0]) acc_d = sum[AluW-1:0];
        y_d = y_q >> 1;
      end
      ALU_DIV: begin
        // The carry out is set when the shifted remainder reaches the divisor.
        acc_d = sum[AluW] ? sum[AluW-1:0] : rsh;
        quo_d = {quo_q[AluW-2:0], sum[AluW]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ALU_MUL;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      op_q   <= req_i.op;
      cnt_q  <= req_i.n;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - AluCntW'(1);
      busy_q <= (cnt_q != AluCntW'(1));
      done_q <= (cnt_q == AluCntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      quo_q <= '0;
      y_q   <= req_i.b;
      x_q   <= (req_i.op == ALU_DIV) ? (req_i.a << pre_sh) : req_i.a;
    end else if (busy_q) begin
      acc_q <= acc_d;
      quo_q <= quo_d;
      x_q   <= x_d;
      y_q   <= y_d;
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == ALU_DIV) ? quo_q : acc_q;

  `AVS_ASSERT(a_start_when_free, clk_i, rst_ni, req_i.start |-> !busy_q)
  `AVS_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> (!busy_q && $past(busy_q)))

endmodule

`default_nettype wire

/* src/adaptive_velocity_smoother_unit.sv */
// ----------------------------------------------------------------------------
// adaptive_velocity_smoother_unit
// Adaptive one-pole parameter smoother with a velocity-driven time constant.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake     Word
//  in_i     in   valid/ready   sample_in (signed, SAMPLE_BITS)
//  out_o    out  valid/ready   sample_out, fast_mode, tau_used_us
//  cfg_i    in   valid/ready   index (3 bits), data (18 bits)
//
//  A word is accepted only in the idle state, so no new word enters until
//  the sequencer has finished the last one and handed it to the output register.
//  The pace is set by the shared 64-bit shift-add/subtract unit, which
//  retires one multiplier or quotient bit a cycle; each word runs ten
//  operations on it (five in fixed mode).
//  Reset restores the register defaults and clears the filter state at once.
//  A finished word waits in the output register; the next word is accepted
//  meanwhile, and the sequencer holds its last step if the register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module adaptive_velocity_smoother_unit import avs_pkg::*; #(
  parameter int SAMPLE_BITS     = SampleBitsDef,
  parameter int EXP_TABLE_DEPTH = ExpTableDepthDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  avs_in_if.sink     in_i,
  avs_out_if.source  out_o,
  avs_cfg_if.sink    cfg_i
);

  localparam int N      = SAMPLE_BITS;
  localparam int Guard  = 32 - N;
  localparam int TabN   = (EXP_TABLE_DEPTH < ExpRomCap) ? EXP_TABLE_DEPTH : ExpRomCap;
  localparam int TabAW  = (TabN > 1) ? $clog2(TabN) : 1;
  localparam int IdxW   = AluW - ArgFracBits;
  localparam logic [32:0] RoundHalf = (33'd1 << Guard) >> 1;
  localparam logic signed [N+1:0] YMax = (N+2)'((64'd1 << (N - 1)) - 64'd1);
  localparam logic signed [N+1:0] YMin = -YMax - (N+2)'(1);

  typedef logic [16:0] exp_rom_t [TabN];

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    t;
    logic [63:0] p;
    logic [63:0] prod;
    p = 64'd1 << 32;
    for (int i = 0; i < TabN; i++) begin
      t[i] = 17'((p + 64'd32768) >> 16);
      prod = p * ExpStepR;
      p    = (prod + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam exp_rom_t ExpRom = build_exp_rom();

  // Configuration registers.
  logic [17:0] fs_q;
  logic [13:0] fast_q;
  logic [15:0] slow_q;
  logic [11:0] sens_q;
  logic [11:0] hyst_q;
  logic        adapt_q;
  logic [15:0] fixed_q;

  // Sequencer and filter state.
  avs_state_e          state_q, state_d;
  logic                issued_q;
  exp_use_e            exp_sel_q;
  logic signed [N-1:0] in_q;
  logic signed [N-1:0] last_q;
  logic signed [31:0]  acc_q;
  logic                mode_q;

  // Datapath registers.
  logic [N-1:0]  ad_q;
  logic [31:0]   s_mag_q;
  logic          s_neg_q;
  logic [63:0]   thr_q, vf_q, exp_arg_q;
  logic [16:0]   hi_q;
  logic [27:0]   e_q;
  logic [15:0]   tau_q;
  logic [33:0]   den_q;
  logic [30:0]   coef_q;

  logic                out_valid_q;
  logic signed [N-1:0] out_sample_q;
  logic                out_mode_q;
  logic [15:0]         out_tau_q;

  logic [16:0] rom_q;
  logic        rom_ok_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  avs_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // Saturated register values.
  logic [17:0] fs_c;
  logic [15:0] fast_c, slow_c, fast_eff, fixed_c;
  logic [11:0] sens_c, hyst_c;

  always_comb begin
    fs_c    = clamp18(fs_q, FsMin, FsMax);
    fast_c  = 16'(clamp18(18'(fast_q), FastMin, FastMax));
    slow_c  = 16'(clamp18(18'(slow_q), SlowMin, SlowMax));
    sens_c  = 12'(clamp18(18'(sens_q), SensMin, SensMax));
    hyst_c  = 12'(clamp18(18'(hyst_q), HystMin, HystMax));
    fixed_c = 16'(clamp18(18'(fixed_q), FixedMin, FixedMax));
    fast_eff = (fast_c > slow_c) ? (slow_c >> 1) : fast_c;
  end

  // Difference and pre-scaled accumulator input.
  logic signed [N:0]  diff;
  logic [N:0]         diff_abs;
  logic signed [33:0] diff_sh, s_sum;
  logic signed [31:0] s_sat;

  always_comb begin
    diff     = {in_q[N-1], in_q} - {last_q[N-1], last_q};
    diff_abs = diff[N] ? (~diff + (N+1)'(1)) : diff;
    diff_sh  = 34'(diff) <<< Guard;
    s_sum    = diff_sh + 34'(acc_q);
    if (s_sum > 34'sd2147483647) s_sat = 32'sh7fffffff;
    else if (s_sum < -34'sd2147483648) s_sat = 32'sh80000000;
    else s_sat = 32'(s_sum);
  end

  // Table lookup addressing.
  logic [IdxW-1:0]  exp_idx;
  logic [10:0]      exp_frac;
  logic             rom_ok;
  logic [TabAW-1:0] rom_addr;
  logic [IdxW-1:0]  idx_next;
  logic [16:0]      rom_val;

  always_comb begin
    exp_idx  = exp_arg_q[AluW-1:ArgFracBits];
    exp_frac = exp_arg_q[ArgFracBits-1:0];
    idx_next = exp_idx + IdxW'(1);
    if (state_q == ST_EXP_HI) begin
      rom_ok   = (exp_idx < IdxW'(TabN));
      rom_addr = exp_idx[TabAW-1:0];
    end else begin
      rom_ok   = (exp_idx < IdxW'(TabN - 1));
      rom_addr = idx_next[TabAW-1:0];
    end
    rom_val = rom_ok_q ? rom_q : 17'd0;
  end

  always_ff @(posedge clk_i) begin
    rom_ok_q <= rom_ok;
    if (rom_ok) rom_q <= ExpRom[rom_addr];
  end

  // Operation results.
  logic [16:0] tau_raw;
  logic [15:0] tau_new;
  logic [28:0] den2;
  logic [33:0] acc_q_rnd;
  logic [31:0] acc_new;

  always_comb begin
    tau_raw = 17'(fast_eff) + 17'((alu_rsp.result + 64'd67108864) >> 27);
    if (tau_raw < 17'(fast_eff)) tau_new = fast_eff;
    else if (tau_raw > 17'(slow_c)) tau_new = slow_c;
    else tau_new = tau_raw[15:0];
    den2      = OneQ27 + 29'(e_q);
    acc_q_rnd = 34'((alu_rsp.result + 64'd536870912) >> 30);
    if (s_neg_q) acc_new = ~acc_q_rnd[31:0] + 32'd1;
    else if (acc_q_rnd > 34'h7fffffff) acc_new = 32'h7fffffff;
    else acc_new = acc_q_rnd[31:0];
  end

  // Output sample.
  logic [31:0]         acc_mag;
  logic [32:0]         q2;
  logic signed [N+1:0] q2s, y_sum;
  logic signed [N-1:0] y_sat;

  always_comb begin
    acc_mag = acc_q[31] ? (~acc_q + 32'd1) : acc_q;
    q2      = ({1'b0, acc_mag} + RoundHalf) >> Guard;
    q2s     = $signed({1'b0, (N+1)'(q2)});
    y_sum   = (N+2)'(last_q) + (acc_q[31] ? -q2s : q2s);
    if (y_sum > YMax) y_sat = N'(YMax);
    else if (y_sum < YMin) y_sat = N'(YMin);
    else y_sat = N'(y_sum);
  end

  logic out_free;
  logic in_fire;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_fire  = in_i.valid && in_i.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_fire) state_d = ST_DIFF;
      ST_DIFF:     state_d = adapt_q ? ST_THR : ST_DEN;
      ST_THR:      if (alu_rsp.done) state_d = ST_VF;
      ST_VF:       if (alu_rsp.done) state_d = ST_MODE;
      ST_MODE:     state_d = ST_ARG;
      ST_ARG:      if (alu_rsp.done) state_d = ST_EXP_HI;
      ST_EXP_HI:   state_d = ST_EXP_LO;
      ST_EXP_LO:   state_d = ST_EXP_MUL;
      ST_EXP_MUL: begin
        if (alu_rsp.done) state_d = (exp_sel_q == EXP_FOR_ETA) ? ST_COEF_DIV : ST_TAU;
      end
      ST_TAU:      if (alu_rsp.done) state_d = ST_DEN;
      ST_DEN:      if (alu_rsp.done) state_d = ST_ETA_DIV;
      ST_ETA_DIV:  if (alu_rsp.done) state_d = ST_EXP_HI;
      ST_COEF_DIV: if (alu_rsp.done) state_d = ST_ACC_MUL;
      ST_ACC_MUL:  if (alu_rsp.done) state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Unit requests.
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    alu_req.n     = '0;
    unique case (state_q)
      ST_THR: begin
        alu_req.a = 64'(hyst_c);
        alu_req.b = 64'(sens_c);
        alu_req.n = AluCntW'(12);
      end
      ST_VF: begin
        alu_req.a = 64'(ad_q);
        alu_req.b = 64'(fs_c);
        alu_req.n = AluCntW'(18);
      end
      ST_ARG: begin
        alu_req.a = vf_q;
        alu_req.b = 64'(sens_c);
        alu_req.n = AluCntW'(12);
      end
      ST_EXP_MUL: begin
        alu_req.a = 64'(hi_q - rom_val);
        alu_req.b = 64'(exp_frac);
        alu_req.n = AluCntW'(11);
      end
      ST_TAU: begin
        alu_req.a = 64'(slow_c - fast_eff);
        alu_req.b = 64'(e_q);
        alu_req.n = AluCntW'(28);
      end
      ST_DEN: begin
        alu_req.a = 64'(fs_c);
        alu_req.b = 64'(tau_q);
        alu_req.n = AluCntW'(16);
      end
      ST_ETA_DIV: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = EtaNum + 64'(den_q >> 1);
        alu_req.b  = 64'(den_q);
        alu_req.n  = AluCntW'(37);
      end
      ST_COEF_DIV: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = (64'(OneQ27 - 29'(e_q)) << 30) + 64'(den2 >> 1);
        alu_req.b  = 64'(den2);
        alu_req.n  = AluCntW'(58);
      end
      ST_ACC_MUL: begin
        alu_req.a = 64'(s_mag_q);
        alu_req.b = 64'(coef_q);
        alu_req.n = AluCntW'(31);
      end
      default: ;
    endcase
    alu_req.start = (alu_req.n != '0) && !issued_q;
  end

  // Control and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      exp_sel_q   <= EXP_FOR_TAU;
      last_q      <= '0;
      acc_q       <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fs_q        <= FsRst;
      fast_q      <= FastRst;
      slow_q      <= SlowRst;
      sens_q      <= SensRst;
      hyst_q      <= HystRst;
      adapt_q     <= 1'b1;
      fixed_q     <= FixedRst;
    end else begin
      state_q <= state_d;
      if (alu_req.start) issued_q <= 1'b1;
      else if (alu_rsp.done) issued_q <= 1'b0;

      if (cfg_i.valid) begin
        unique case (cfg_idx_e'(cfg_i.index))
          REG_FS:    fs_q    <= cfg_i.data;
          REG_FAST:  fast_q  <= cfg_i.data[13:0];
          REG_SLOW:  slow_q  <= cfg_i.data[15:0];
          REG_SENS:  sens_q  <= cfg_i.data[11:0];
          REG_HYST:  hyst_q  <= cfg_i.data[11:0];
          REG_ADAPT: begin
            adapt_q <= cfg_i.data[0];
            if (!cfg_i.data[0]) mode_q <= 1'b0;
          end
          REG_FIXED: fixed_q <= cfg_i.data[15:0];
          default: ;
        endcase
      end

      // Enter fast mode above the threshold, leave below half of it.
      if (state_q == ST_MODE) begin
        if (!mode_q && ((vf_q << 5) > thr_q)) mode_q <= 1'b1;
        else if (mode_q && ((vf_q << 6) < thr_q)) mode_q <= 1'b0;
      end

      if (state_q == ST_ARG && alu_rsp.done) exp_sel_q <= EXP_FOR_TAU;
      if (state_q == ST_ETA_DIV && alu_rsp.done) exp_sel_q <= EXP_FOR_ETA;
      if (state_q == ST_ACC_MUL && alu_rsp.done) acc_q <= $signed(acc_new);

      if (state_q == ST_OUT && out_free) begin
        last_q      <= y_sat;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath captures.
  always_ff @(posedge clk_i) begin
    if (in_fire) in_q <= in_i.sample_in;
    if (state_q == ST_DIFF) begin
      ad_q    <= diff_abs[N-1:0];
      s_neg_q <= s_sat[31];
      s_mag_q <= s_sat[31] ? (~s_sat + 32'd1) : s_sat;
      if (!adapt_q) tau_q <= fixed_c;
    end
    if (alu_rsp.done) begin
      unique case (state_q)
        ST_THR:      thr_q <= alu_rsp.result << (N - 16);
        ST_VF:       vf_q <= alu_rsp.result;
        ST_ARG:      exp_arg_q <= alu_rsp.result >> (N - 9);
        ST_EXP_MUL:  e_q <= 28'((64'(hi_q) << ArgFracBits) - alu_rsp.result);
        ST_TAU:      tau_q <= tau_new;
        ST_DEN:      den_q <= alu_rsp.result[33:0];
        ST_ETA_DIV:  exp_arg_q <= alu_rsp.result;
        ST_COEF_DIV: coef_q <= alu_rsp.result[30:0];
        default: ;
      endcase
    end
    if (state_q == ST_EXP_LO) hi_q <= rom_val;
    if (state_q == ST_OUT && out_free) begin
      out_sample_q <= y_sat;
      out_mode_q   <= mode_q;
      out_tau_q    <= tau_q;
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.sample_out  = out_sample_q;
  assign out_o.fast_mode   = out_mode_q;
  assign out_o.tau_used_us = out_tau_q;

  logic out_tau_ok;
  assign out_tau_ok = (out_tau_q >= 16'd100) && (out_tau_q <= 16'd50000);

  `AVS_ASSERT_NEXT(a_accept_starts_diff, clk_i, rst_ni, in_fire, state_q == ST_DIFF)
  `AVS_ASSERT_NEXT(a_tau_in_range, clk_i, rst_ni, (state_q == ST_OUT) && out_free, out_tau_ok)

endmodule

`default_nettype wire

/* tb/adaptive_velocity_smoother_unit_tb.sv */
// ----------------------------------------------------------------------------
// adaptive_velocity_smoother_unit_tb
// Drives parameter samples and register writes into the smoother, predicts
// every result word from a bit-exact model of its own and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_velocity_smoother_unit_tb;
  import avs_pkg::*;

  localparam int SW = 24;
  localparam int TDEPTH = 256;
  localparam int GUARD = 32 - SW;

  typedef struct {
    logic signed [SW-1:0] smp;
    logic                 fmode;
    logic [15:0]          tau;
  } smooth_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  avs_in_if #(.W(SW)) in_if ();
  avs_out_if #(.W(SW)) out_if ();
  avs_cfg_if cfg_if ();

  adaptive_velocity_smoother_unit #(.SAMPLE_BITS(SW), .EXP_TABLE_DEPTH(TDEPTH)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state.
  longint unsigned exp_rom[TDEPTH];
  longint unsigned r_fs, r_fast, r_slow, r_sens, r_hyst, r_adapt, r_fixed;
  longint prev_y, acc_st;
  bit mflag;

  logic signed [SW-1:0] sample_queue[$];
  smooth_word_t expected_words[$];
  int mismatches = 0;
  bit all_sent = 1'b0;
  bit drv_busy = 1'b0;

  function automatic longint unsigned clampu(longint unsigned v, longint unsigned lo,
                                             longint unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clamps(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned exp_interp(longint unsigned a);
    longint unsigned idx, frac, hi, lo;
    idx = a >> 11;
    frac = a & 64'h7FF;
    if (idx >= TDEPTH) return 0;
    hi = exp_rom[idx];
    lo = (idx + 1 < TDEPTH) ? exp_rom[idx+1] : 0;
    return (hi << 11) - (hi - lo) * frac;
  endfunction

  task automatic reset_smoother_model();
    longint unsigned p;
    p = 64'd1 << 32;
    for (int i = 0; i < TDEPTH; i++) begin
      exp_rom[i] = (p + 32768) >> 16;
      p = (p * 64'd4162825044 + (64'd1 << 31)) >> 32;
    end
    r_fs = 48000; r_fast = 500; r_slow = 8000; r_sens = 512;
    r_hyst = 205; r_adapt = 1; r_fixed = 10000;
    prev_y = 0; acc_st = 0; mflag = 0;
  endtask

  task automatic write_model_reg(cfg_idx_e idx, longint unsigned v);
    case (idx)
      REG_FS:    r_fs = v & 18'h3FFFF;
      REG_FAST:  r_fast = v & 14'h3FFF;
      REG_SLOW:  r_slow = v & 16'hFFFF;
      REG_SENS:  r_sens = v & 12'hFFF;
      REG_HYST:  r_hyst = v & 12'hFFF;
      REG_ADAPT: begin
        r_adapt = v & 1;
        if (r_adapt == 0) mflag = 0;
      end
      REG_FIXED: r_fixed = v & 16'hFFFF;
      default: ;
    endcase
  endtask

  function automatic smooth_word_t smooth_sample(logic signed [SW-1:0] xin);
    smooth_word_t w;
    longint x, d, s, acc, y;
    longint unsigned ad, fs, tau, den, eta, coef, mag, q;
    longint unsigned fast, slow, sens, hyst, vf, thr, e;
    x = xin;
    d = x - prev_y;
    ad = d < 0 ? -d : d;
    fs = clampu(r_fs, 8000, 192000);
    if (r_adapt != 0) begin
      fast = clampu(r_fast, 100, 10000);
      slow = clampu(r_slow, 1000, 50000);
      sens = clampu(r_sens, 26, 2560);
      hyst = clampu(r_hyst, 41, 2048);
      vf = ad * fs;
      thr = (hyst * sens) << (SW - 16);
      if (fast > slow) fast = slow / 2;
      if (!mflag && (vf << 5) > thr) mflag = 1;
      else if (mflag && (vf << 6) < thr) mflag = 0;
      e = exp_interp((vf * sens) >> (SW - 9));
      tau = fast + (((slow - fast) * e + (64'd1 << 26)) >> 27);
      tau = clampu(tau, fast, slow);
    end else begin
      tau = clampu(r_fixed, 100, 50000);
    end
    den = fs * tau;
    eta = exp_interp((64'd65536000000 + den / 2) / den);
    den = (64'd1 << 27) + eta;
    coef = ((((64'd1 << 27) - eta) << 30) + den / 2) / den;
    s = d * (64'sd1 << GUARD) + acc_st;
    s = clamps(s, -64'sd2147483648, 64'sd2147483647);
    mag = s < 0 ? -s : s;
    q = (mag * coef + (64'd1 << 29)) >> 30;
    acc = s < 0 ? -longint'(q) : longint'(q);
    acc = clamps(acc, -64'sd2147483648, 64'sd2147483647);
    acc_st = acc;
    mag = acc < 0 ? -acc : acc;
    q = (mag + (64'd1 << (GUARD - 1))) >> GUARD;
    y = prev_y + (acc < 0 ? -longint'(q) : longint'(q));
    y = clamps(y, -(64'sd1 << (SW - 1)), (64'sd1 << (SW - 1)) - 1);
    prev_y = y;
    w.smp = y[SW-1:0];
    w.fmode = mflag;
    w.tau = tau[15:0];
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 400);
  endfunction

  // Input driver: the prediction is made when the word is accepted.
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.sample_in <= '0;
      in_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_words.push_back(smooth_sample(in_if.sample_in));
        void'(sample_queue.pop_front());
      end
      // The accepted word has already left the queue here.
      if (in_if.valid && !in_if.ready) begin
        // hold the word
      end else if (in_gap > 0) begin
        in_if.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (sample_queue.size() > 0 && drv_busy) begin
        in_if.valid <= 1'b1;
        in_if.sample_in <= sample_queue[0];
        in_gap <= pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor with a randomly stalling ready.
  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    smooth_word_t exp_w;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %0d", out_if.sample_out);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_if.sample_out !== exp_w.smp || out_if.fast_mode !== exp_w.fmode ||
              out_if.tau_used_us !== exp_w.tau) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp y=%0d fm=%0b tau=%0d got y=%0d fm=%0b tau=%0d",
                       exp_w.smp, exp_w.fmode, exp_w.tau, out_if.sample_out,
                       out_if.fast_mode, out_if.tau_used_us);
          end
        end
      end
      if (out_gap > 0) begin
        out_if.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
      end
    end
  end

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] v);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    write_model_reg(idx, v);
    cfg_if.valid <= 1'b0;
  endtask

  // Send queued samples and wait until the block is idle again.
  task automatic run_phase();
    drv_busy = 1'b1;
    while (sample_queue.size() != 0 || expected_words.size() != 0) @(posedge clk_i);
    drv_busy = 1'b0;
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic signed [SW-1:0] prev_y_hint();
    return sample_queue.size() ? sample_queue[$] : '0;
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return SW'($urandom);
    if (r < 5) return prev_y_hint() + SW'($signed($urandom_range(0, 2000)) - 1000);
    if (r < 6) return r[0] ? 24'sh7FFFFF : 24'sh800000;
    return SW'($signed($urandom_range(0, 200000)) - 100000);
  endfunction

  task automatic random_regs();
    write_reg(REG_FS, $urandom_range(0, 3) == 0 ? CfgDataW'($urandom)
                                                : CfgDataW'($urandom_range(8000, 192000)));
    write_reg(REG_FAST, $urandom_range(0, 4) == 0 ? CfgDataW'($urandom_range(0, 16383))
                                                  : CfgDataW'($urandom_range(100, 10000)));
    write_reg(REG_SLOW, $urandom_range(0, 4) == 0 ? CfgDataW'($urandom_range(0, 65535))
                                                  : CfgDataW'($urandom_range(1000, 50000)));
    write_reg(REG_SENS, CfgDataW'($urandom_range(0, 4095)));
    write_reg(REG_HYST, CfgDataW'($urandom_range(0, 4095)));
    write_reg(REG_ADAPT, CfgDataW'($urandom_range(0, 3) != 0));
    write_reg(REG_FIXED, CfgDataW'($urandom_range(0, 65535)));
  endtask

  initial begin
    reset_smoother_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, steps, hold at reset settings.
    sample_queue = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 0, 1, -1,
                     24'sh555555, 24'shAAAAAA, 0, 100, 200, 0};
    run_phase();
    // Low extremes, fast above slow.
    write_reg(REG_FS, 8000); write_reg(REG_FAST, 10000); write_reg(REG_SLOW, 1000);
    write_reg(REG_SENS, 26); write_reg(REG_HYST, 41);
    sample_queue = '{24'sh7FFFFF, 24'sh800000, 5, 0, 24'sh100000};
    run_phase();
    // High extremes and out-of-range values, fixed mode.
    write_reg(REG_FS, 18'h3FFFF); write_reg(REG_FAST, 0); write_reg(REG_SLOW, 16'hFFFF);
    write_reg(REG_SENS, 12'hFFF); write_reg(REG_HYST, 12'hFFF);
    sample_queue = '{24'sh7FFFFF, 0, 10};
    run_phase();
    write_reg(REG_ADAPT, 0); write_reg(REG_FIXED, 0);
    sample_queue = '{24'sh800000, 24'sh7FFFFF};
    run_phase();
    write_reg(REG_FIXED, 16'hFFFF); write_reg(REG_ADAPT, 1); write_reg(REG_FS, 0);
    sample_queue = '{24'sh7FFFFF, 3};
    run_phase();

    for (int ph = 0; ph < 16; ph++) begin
      random_regs();
      for (int k = 0; k < 50; k++) sample_queue.push_back(rand_sample());
      run_phase();
    end
    all_sent = 1'b1;
  end

  initial begin
    wait (all_sent);
    if (mismatches == 0) $display("** adaptive_velocity_smoother_unit: PASSED **");
    else $display("** adaptive_velocity_smoother_unit: FAILED **");
    $finish;
  end

  initial begin
    #20000000;
    $display("** adaptive_velocity_smoother_unit: FAILED **");
    $finish;
  end

endmodule
